/* design/lgfr_pkg.sv */
// ----------------------------------------------------------------------------
// lgfr_pkg
// Shared widths, codes and types of the linear gain fade ramp.
// ----------------------------------------------------------------------------
package lgfr_pkg;

    // Audio and gain formats
    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int ACC_EXTRA      = 16;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 2;
    localparam int ACC_W          = GAIN_W + ACC_EXTRA;

    // Fade length terms
    localparam int RATE_W   = 18;
    localparam int CHAN_W   = 4;
    localparam int MS_W     = 16;
    localparam int RC_W     = RATE_W + CHAN_W;
    localparam int DEN_W    = RC_W + MS_W;

    // Slope = |diff| * 1000 / den, 1000 fits in 10 bits
    localparam int FADE_SCALE = 1000;
    localparam int SCALE_W    = 10;
    localparam int DIFF_W     = ACC_W + 1;
    localparam int NUM_W      = ACC_W + SCALE_W;
    localparam int SLOPE_W    = NUM_W + 1;
    localparam int SUM_W      = SLOPE_W + 1;
    localparam int PROD_W     = SAMPLE_BITS + GAIN_W + 1;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RATE_W;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SAMPLE_RATE   = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_CHANNEL_COUNT = t_cfg_idx'(1);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
    localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);

    // Request type codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FADE   = 1'b1;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_JUMP,
        KIND_RAMP
    } t_kind;

    typedef struct packed {
        t_kind                          kind;
        logic signed [SAMPLE_BITS-1:0]  sample;
        logic [GAIN_W-1:0]              target;
        logic [MS_W-1:0]                ms;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMP,
        ST_PREP,
        ST_START,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [NUM_W-1:0]   quo;
    } t_div_rsp;

endpackage

/* design/lgfr_ifs.sv */
// ----------------------------------------------------------------------------
// lgfr channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lgfr_req_if import lgfr_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic signed [SAMPLE_BITS-1:0]  sample_in;
    logic [GAIN_W-1:0]              target_gain;
    logic [MS_W-1:0]                fade_time_ms;

    modport source (output valid, req_type, sample_in, target_gain, fade_time_ms,
                    input ready);
    modport sink   (input valid, req_type, sample_in, target_gain, fade_time_ms,
                    output ready);
endinterface

interface lgfr_res_if import lgfr_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_BITS-1:0]  sample_out;
    logic                           fade_done;

    modport source (output valid, sample_out, fade_done, input ready);
    modport sink   (input valid, sample_out, fade_done, output ready);
endinterface

interface lgfr_cfg_if import lgfr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/lgfr_front.sv */
// ----------------------------------------------------------------------------
// lgfr_front
// Accepts requests and classifies them into sample, jump or ramp commands.
// ----------------------------------------------------------------------------
module lgfr_front import lgfr_pkg::*; (
    lgfr_req_if.sink            i_req,
    input  logic [RATE_W-1:0]   i_rate,
    input  logic [CHAN_W-1:0]   i_chan,
    input  logic                i_full,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic zero_len;

    // zero length or zero denominator term -> immediate jump
    assign zero_len = (i_req.fade_time_ms == '0) || (i_rate == '0) || (i_chan == '0);

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        o_cmd.sample = i_req.sample_in;
        o_cmd.target = i_req.target_gain;
        o_cmd.ms     = i_req.fade_time_ms;
        if (i_req.req_type == REQ_SAMPLE) begin
            o_cmd.kind = KIND_SAMPLE;
        end else if (zero_len) begin
            o_cmd.kind = KIND_JUMP;
        end else begin
            o_cmd.kind = KIND_RAMP;
        end
    end

endmodule

/* design/lgfr_queue.sv */
// ----------------------------------------------------------------------------
// lgfr_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module lgfr_queue import lgfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output logic    o_full,
    output logic    o_empty
);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_push;
    logic               do_pop;

    // reads as full while in reset so no request is taken and then lost
    assign o_full  = !i_rst_n || (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* design/lgfr_div.sv */
// ----------------------------------------------------------------------------
// lgfr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lgfr_div import lgfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output t_div_rsp    o_rsp
);

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DEN_W-1:0]       r_rem;
    logic [DEN_W-1:0]       r_den;
    logic [NUM_W-1:0]       r_quo;
    logic [DEN_W:0]         trial;
    logic [DEN_W:0]         trial_sub;
    logic                   ge;

    assign trial     = {r_rem, r_quo[NUM_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign ge        = (trial >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so the difference fits DEN_W
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

endmodule

/* design/lgfr_back.sv */
// ----------------------------------------------------------------------------
// lgfr_back
// Executes queued commands: scales samples, steps the gain, computes slopes.
// ----------------------------------------------------------------------------
module lgfr_back import lgfr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_head,
    input  logic                i_empty,
    output logic                o_pop,
    input  logic [RATE_W-1:0]   i_rate,
    input  logic [CHAN_W-1:0]   i_chan,
    output t_div_req            o_div,
    input  t_div_rsp            i_div,
    lgfr_res_if.source          o_res
);

    t_state                         r_state;
    t_state                         n_state;

    logic [ACC_W-1:0]               r_cur;
    logic signed [SLOPE_W-1:0]      r_slope;
    logic [GAIN_W-1:0]              r_goal;

    logic signed [PROD_W-1:0]       r_prod;
    logic signed [DIFF_W-1:0]       r_diff;
    logic [RC_W-1:0]                r_rc;
    logic [MS_W-1:0]                r_ms;
    logic [DEN_W-1:0]               r_den;
    logic [ACC_W-1:0]               r_mag;
    logic                           r_neg;

    logic                           r_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_out_sample;
    logic                           r_out_done;

    logic                           out_free;
    logic                           load_out;
    logic                           div_start;

    logic signed [PROD_W-1:0]       rounded;
    logic signed [PROD_W-1:0]       shifted;
    logic [PROD_W-SAMPLE_BITS:0]    top_bits;
    logic signed [SAMPLE_BITS-1:0]  sat;
    logic signed [SUM_W-1:0]        sum;
    logic [ACC_W-1:0]               acc;
    logic [ACC_W-1:0]               goal_acc;
    logic                           slope_neg;
    logic                           slope_pos;
    logic                           reach;
    logic [DIFF_W-1:0]              mag_full;
    logic [SLOPE_W-1:0]             quo_ext;

    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        load_out  = 1'b0;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_head.kind)
                        KIND_SAMPLE: n_state = ST_SAMP;
                        KIND_RAMP:   n_state = ST_PREP;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SAMP: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_PREP: n_state = ST_START;
            ST_START: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (i_div.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_div.start = div_start;
    assign o_div.num   = NUM_W'(r_mag) * NUM_W'(FADE_SCALE);
    assign o_div.den   = r_den;

    // output rounding (half up, floor shift) and saturation
    assign rounded  = r_prod + $signed(PROD_W'(1) <<< (GAIN_FRAC_BITS - 1));
    assign shifted  = rounded >>> GAIN_FRAC_BITS;
    assign top_bits = shifted[PROD_W-1:SAMPLE_BITS-1];

    always_comb begin
        if ((&top_bits) || !(|top_bits)) begin
            sat = shifted[SAMPLE_BITS-1:0];
        end else if (shifted[PROD_W-1]) begin
            sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // gain step, clamped to the accumulator range
    assign sum = $signed({{(SUM_W-ACC_W){1'b0}}, r_cur}) + {r_slope[SLOPE_W-1], r_slope};

    always_comb begin
        if (sum[SUM_W-1]) begin
            acc = '0;
        end else if (|sum[SUM_W-2:ACC_W]) begin
            acc = '1;
        end else begin
            acc = sum[ACC_W-1:0];
        end
    end

    assign goal_acc  = {r_goal, {ACC_EXTRA{1'b0}}};
    assign slope_neg = r_slope[SLOPE_W-1];
    assign slope_pos = !slope_neg && (|r_slope);
    assign reach     = (slope_neg && (acc <= goal_acc)) || (slope_pos && (acc >= goal_acc));

    assign mag_full = r_diff[DIFF_W-1] ? (~r_diff + 1'b1) : r_diff;
    assign quo_ext  = {1'b0, i_div.quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_slope <= '0;
            r_goal  <= '0;
        end else begin
            if (o_pop && (i_head.kind == KIND_JUMP)) begin
                r_cur   <= {i_head.target, {ACC_EXTRA{1'b0}}};
                r_slope <= '0;
                r_goal  <= i_head.target;
            end else if (o_pop && (i_head.kind == KIND_RAMP)) begin
                r_goal  <= i_head.target;
            end else if (load_out) begin
                r_cur <= reach ? goal_acc : acc;
                if (reach) begin
                    r_slope <= '0;
                end
            end else if ((r_state == ST_DIV) && i_div.done) begin
                r_slope <= r_neg ? $signed(~quo_ext + 1'b1) : $signed(quo_ext);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod <= $signed(i_head.sample) * $signed({1'b0, r_cur[ACC_W-1:ACC_EXTRA]});
            r_diff <= $signed({1'b0, i_head.target, {ACC_EXTRA{1'b0}}})
                    - $signed({1'b0, r_cur});
            r_rc   <= i_rate * i_chan;
            r_ms   <= i_head.ms;
        end
        if (r_state == ST_PREP) begin
            r_den <= r_rc * r_ms;
            r_mag <= mag_full[ACC_W-1:0];
            r_neg <= r_diff[DIFF_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_sample <= sat;
            r_out_done   <= reach;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.sample_out = r_out_sample;
    assign o_res.fade_done  = r_out_done;

endmodule

/* design/linear_gain_fade_ramp_core.sv */
// ----------------------------------------------------------------------------
// linear_gain_fade_ramp_core
// Linear audio gain ramp: scales samples by a gain that slews to a target.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | when
//  i_req    | in  | req_type, sample_in, target_gain, fade_time_ms | valid && ready
//  o_res    | out | sample_out, fade_done                          | valid && ready
//  i_cfg    | in  | index, data (0 sample_rate, 1 channel_count)   | valid && ready
//
//  Sample request: in the back stage, queue pop + multiply, then
//  round/saturate/gain step into the output register once it is free.
//  Jump fade: applied at the queue pop. Ramp fade: PREP, START and DIV
//  states; DIV waits on the one bit per cycle slope divider (44 quotient bits).
//  Reset is synchronous, active low; config regs go to 48000 and 2.
//  A 2-deep command queue keeps accepting requests while the output
//  register waits on o_res.ready; i_req.ready drops when the queue is full.
module linear_gain_fade_ramp_core import lgfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lgfr_req_if.sink    i_req,
    lgfr_res_if.source  o_res,
    lgfr_cfg_if.sink    i_cfg
);

    logic [RATE_W-1:0]  r_rate;
    logic [CHAN_W-1:0]  r_chan;

    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    t_cmd               front_cmd;
    t_cmd               head_cmd;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_chan <= CHAN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SAMPLE_RATE:   r_rate <= i_cfg.data[RATE_W-1:0];
                CFG_CHANNEL_COUNT: r_chan <= i_cfg.data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    lgfr_front u_front (
        .i_req  (i_req),
        .i_rate (r_rate),
        .i_chan (r_chan),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    lgfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    lgfr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    lgfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .i_rate  (r_rate),
        .i_chan  (r_chan),
        .o_div   (div_req),
        .i_div   (div_rsp),
        .o_res   (o_res)
    );

endmodule

/* design/lgfr_checker.sv */
// ----------------------------------------------------------------------------
// lgfr_checker
// Port-level checks on the gain ramp core, bound to the top level.
// ----------------------------------------------------------------------------
module lgfr_checker import lgfr_pkg::*; (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic                            i_req_type,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic signed [SAMPLE_BITS-1:0]   i_res_sample,
    input  logic                            i_res_done
);

    logic [2:0] r_pend;
    logic       inc;
    logic       dec;

    // sample requests accepted but not yet delivered
    assign inc = i_req_valid && i_req_ready && (i_req_type == REQ_SAMPLE);
    assign dec = i_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            case ({inc, dec})
                2'b10:   r_pend <= r_pend + 1'b1;
                2'b01:   r_pend <= r_pend - 1'b1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_sample) && $stable(i_res_done))
        else $error("result payload changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (r_pend != 3'd0))
        else $error("result without a pending sample request");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 3'd4) |-> !i_req_ready)
        else $error("request taken with queue and output stage full");

endmodule

bind linear_gain_fade_ramp_core lgfr_checker u_lgfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_type   (i_req.req_type),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_sample (o_res.sample_out),
    .i_res_done   (o_res.fade_done)
);

/* tb/sv/linear_gain_fade_ramp_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_gain_fade_ramp_core_tb
// Drives sample and fade requests through the gain ramp core. Each accepted
// request is run through a fixed-point gain model kept here, and every
// returned sample is checked in order against it. The run uses several rate
// and channel settings, random idling on both channels and one long output
// hold.
// ----------------------------------------------------------------------------
module linear_gain_fade_ramp_core_tb;
    import lgfr_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    // up to three ramp fades can still be in flight
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 115;
    localparam longint ACC_MAX   = (longint'(1) <<< ACC_W) - 1;
    // index decoded by neither register, the write must change nothing
    localparam t_cfg_idx CFG_UNUSED = t_cfg_idx'(3);

    // rate / channel data per random phase; channel data carries junk high bits
    localparam logic [CFG_DATA_W-1:0] RATE_SET [PHASES] =
        '{18'd8000, 18'd192000, 18'd0, 18'h3FFFF, 18'd16000, 18'd8000};
    localparam logic [CFG_DATA_W-1:0] CHAN_SET [PHASES] =
        '{18'd1, 18'd8, 18'd2, 18'h0000F, 18'h3FFF0, 18'h3FFF2};

    typedef struct packed {
        logic                          req_type;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [GAIN_W-1:0]             target;
        logic [MS_W-1:0]               ms;
        logic                          typed;
        logic signed [SAMPLE_BITS-1:0] want_sample;
        logic                          want_done;
    } t_stim_row;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          fade_done;
    } t_gain_out;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lgfr_req_if req_ch ();
    lgfr_res_if res_ch ();
    lgfr_cfg_if cfg_ch ();

    linear_gain_fade_ramp_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // gain model state
    logic [ACC_W-1:0]  gain_acc;
    longint            ramp_step;
    logic [GAIN_W-1:0] goal_level;
    logic [RATE_W-1:0] rate_reg;
    logic [CHAN_W-1:0] chan_reg;

    t_gain_out scaled_q[$];
    t_stim_row dir_rows[$];

    int err_count     = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int phase_no      = -1;
    int stall_cycles  = 0;
    logic hold_out    = 1'b0;

    task automatic note_mismatch(string msg);
        $display("%0t ns  mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void load_fade(logic [GAIN_W-1:0] tgt, logic [MS_W-1:0] ms);
        longint rate_l, chan_l, ms_l, den, tgt_l, cur_l;
        rate_l = rate_reg;
        chan_l = chan_reg;
        ms_l   = ms;
        den    = rate_l * chan_l * ms_l;
        tgt_l  = tgt;
        tgt_l  = tgt_l <<< ACC_EXTRA;
        cur_l  = gain_acc;
        goal_level = tgt;
        if (den == 0) begin
            // zero length or zero divisor: immediate jump
            gain_acc  = tgt_l[ACC_W-1:0];
            ramp_step = 0;
        end else begin
            ramp_step = ((tgt_l - cur_l) * FADE_SCALE) / den;
        end
    endfunction

    function automatic t_gain_out scale_sample(logic signed [SAMPLE_BITS-1:0] s);
        longint smp, g, p, acc, goal;
        t_gain_out y;
        smp  = s;
        g    = gain_acc[ACC_W-1:ACC_EXTRA];
        p    = (smp * g + (longint'(1) <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        acc  = gain_acc;
        acc  = acc + ramp_step;
        if (acc < 0) acc = 0;
        if (acc > ACC_MAX) acc = ACC_MAX;
        goal = goal_level;
        goal = goal <<< ACC_EXTRA;
        y.fade_done = 1'b0;
        if ((ramp_step < 0 && acc <= goal) || (ramp_step > 0 && acc >= goal)) begin
            acc         = goal;
            ramp_step   = 0;
            y.fade_done = 1'b1;
        end
        gain_acc     = acc[ACC_W-1:0];
        y.sample_out = p[SAMPLE_BITS-1:0];
        return y;
    endfunction

    function automatic t_stim_row rand_row();
        t_stim_row r;
        int k;
        r = '0;
        if ($urandom_range(99) < 8) begin
            r.req_type = REQ_FADE;
            case ($urandom_range(7))
                0:       r.target = '0;
                1:       r.target = GAIN_W'(65536);
                2:       r.target = GAIN_W'(131072);
                3:       r.target = GAIN_W'($urandom_range(262143, 131073));
                default: r.target = GAIN_W'($urandom_range(131072));
            endcase
            k = $urandom_range(99);
            if (k < 25)      r.ms = '0;
            else if (k < 75) r.ms = MS_W'($urandom_range(2, 1));
            else if (k < 95) r.ms = MS_W'($urandom_range(20, 3));
            else             r.ms = MS_W'($urandom_range(65535));
            r.sample = SAMPLE_BITS'($urandom);
        end else begin
            r.req_type = REQ_SAMPLE;
            if ($urandom_range(99) < 10)
                r.sample = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            else
                r.sample = SAMPLE_BITS'($urandom);
            r.target = GAIN_W'($urandom);
            r.ms     = MS_W'($urandom);
        end
        return r;
    endfunction

    task automatic send_row(t_stim_row r);
        t_gain_out y;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= r.req_type;
        req_ch.sample_in    <= r.sample;
        req_ch.target_gain  <= r.target;
        req_ch.fade_time_ms <= r.ms;
        do @(posedge i_clk); while (!req_ch.ready);
        if (r.req_type == REQ_FADE) begin
            load_fade(r.target, r.ms);
        end else begin
            y = scale_sample(r.sample);
            if (r.typed) begin
                y.sample_out = r.want_sample;
                y.fade_done  = r.want_done;
            end
            scaled_q.push_back(y);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CFG_SAMPLE_RATE)
            rate_reg = val[RATE_W-1:0];
        else if (idx == CFG_CHANNEL_COUNT)
            chan_reg = val[CHAN_W-1:0];
    endtask

    // drop valid, wait out every pending sample, then let the core settle
    task automatic drain_outputs(int settle);
        req_ch.valid <= 1'b0;
        while (scaled_q.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // output side: random backpressure plus in-order checking
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !hold_out && ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (scaled_q.size() == 0) begin
                note_mismatch($sformatf("sample %0d with no request pending",
                                        res_ch.sample_out));
            end else begin
                if (res_ch.sample_out !== scaled_q[0].sample_out)
                    note_mismatch($sformatf("sample_out got %0d want %0d",
                                            res_ch.sample_out, scaled_q[0].sample_out));
                if (res_ch.fade_done !== scaled_q[0].fade_done)
                    note_mismatch($sformatf("fade_done got %0b want %0b",
                                            res_ch.fade_done, scaled_q[0].fade_done));
                void'(scaled_q.pop_front());
            end
        end
    end

    // long output hold in the second phase so the input queue fills and stalls
    initial begin
        while (phase_no != 1)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_stim_row r;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_SAMPLE;
        req_ch.sample_in    <= '0;
        req_ch.target_gain  <= '0;
        req_ch.fade_time_ms <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_SAMPLE_RATE;
        cfg_ch.data         <= '0;
        i_rst_n             <= 1'b0;
        gain_acc   = '0;
        ramp_step  = 0;
        goal_level = '0;
        rate_reg   = RATE_RESET;
        chan_reg   = CHAN_RESET;

        // typed rows follow from unity / double / zero gain; the rest use the model
        dir_rows = '{
            '{REQ_SAMPLE, 16'sh7FFF, 18'd0, 16'd0, 1'b1, 16'sd0, 1'b0},
            '{REQ_SAMPLE, 16'sh8000, 18'd0, 16'd0, 1'b1, 16'sd0, 1'b0},
            '{REQ_FADE, 16'sd0, 18'd65536, 16'd0, 1'b0, 16'sd0, 1'b0},
            '{REQ_SAMPLE, 16'sd12345, 18'd0, 16'd0, 1'b1, 16'sd12345, 1'b0},
            '{REQ_SAMPLE, 16'sh8000, 18'd0, 16'd0, 1'b1, 16'sh8000, 1'b0},
            '{REQ_SAMPLE, -16'sd1, 18'd0, 16'd0, 1'b1, -16'sd1, 1'b0},
            '{REQ_FADE, 16'sd0, 18'd131072, 16'd0, 1'b0, 16'sd0, 1'b0},
            '{REQ_SAMPLE, 16'sh7FFF, 18'd0, 16'd0, 1'b1, 16'sh7FFF, 1'b0},
            '{REQ_SAMPLE, 16'sh8000, 18'd0, 16'd0, 1'b1, 16'sh8000, 1'b0},
            '{REQ_SAMPLE, 16'sd1000, 18'd0, 16'd0, 1'b1, 16'sd2000, 1'b0},
            '{REQ_FADE, 16'sd0, 18'h3FFFF, 16'd0, 1'b0, 16'sd0, 1'b0},
            '{REQ_SAMPLE, -16'sd20000, 18'd0, 16'd0, 1'b1, 16'sh8000, 1'b0},
            '{REQ_SAMPLE, 16'sd5, 18'd0, 16'd0, 1'b0, 16'sd0, 1'b0},
            '{REQ_FADE, 16'sd0, 18'd0, 16'd0, 1'b0, 16'sd0, 1'b0},
            '{REQ_SAMPLE, 16'sh7FFF, 18'd0, 16'd0, 1'b1, 16'sd0, 1'b0},
            // slope truncates to zero: gain stays at zero, no done
            '{REQ_FADE, 16'sd0, 18'd1, 16'hFFFF, 1'b0, 16'sd0, 1'b0},
            '{REQ_SAMPLE, 16'sh7FFF, 18'd0, 16'd0, 1'b1, 16'sd0, 1'b0},
            '{REQ_SAMPLE, 16'sh8000, 18'd0, 16'd0, 1'b1, 16'sd0, 1'b0},
            '{REQ_FADE, 16'sd0, 18'd65536, 16'd1, 1'b0, 16'sd0, 1'b0},
            '{REQ_SAMPLE, 16'sd21845, 18'd0, 16'd0, 1'b0, 16'sd0, 1'b0},
            '{REQ_SAMPLE, -16'sd21846, 18'd0, 16'd0, 1'b0, 16'sd0, 1'b0},
            '{REQ_FADE, 16'sd0, 18'd0, 16'hFFFF, 1'b0, 16'sd0, 1'b0},
            '{REQ_SAMPLE, 16'sh5555, 18'd0, 16'd0, 1'b0, 16'sd0, 1'b0},
            '{REQ_SAMPLE, -16'sd1, 18'd0, 16'd0, 1'b0, 16'sd0, 1'b0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_UNUSED, 18'h3FFFF);
        cfg_ch.valid <= 1'b0;

        send_idle_pct = 16;
        recv_idle_pct = 72;
        foreach (dir_rows[i])
            send_row(dir_rows[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_outputs(SETTLE_CYCLES);
            write_reg(CFG_SAMPLE_RATE, RATE_SET[ph]);
            write_reg(CFG_CHANNEL_COUNT, CHAN_SET[ph]);
            cfg_ch.valid <= 1'b0;
            case (ph / 2)
                0: begin send_idle_pct = 16; recv_idle_pct = 72; end
                1: begin send_idle_pct = 72; recv_idle_pct = 16; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_no = ph;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // one sender pause until the output side has caught up
                if (ph == 3 && n == 60)
                    drain_outputs(0);
                r = rand_row();
                send_row(r);
            end
        end

        drain_outputs(SETTLE_CYCLES);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
